// ===== design/cgl_pkg.sv =====
package cgl_pkg;

  localparam int PALETTE_DEPTH = 16;
  localparam int FRAC_BITS     = 16;

  localparam int IDX_W    = $clog2(PALETTE_DEPTH);
  localparam int POS_W    = FRAC_BITS + 2;
  localparam int CNT_W    = 5;
  localparam int CHAN_W   = 8;
  localparam int NUM_CHAN = 4;
  localparam int ENTRY_W  = CHAN_W * NUM_CHAN;
  localparam int SCALED_W = FRAC_BITS + IDX_W;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [ENTRY_W-1:0]   entry_t;
  typedef logic [CHAN_W-1:0]    chan_t;

  // two palette addresses and the blend weight for one lookup
  typedef struct packed {
    idx_t  addr0;
    idx_t  addr1;
    frac_t frac;
  } lookup_t;

  typedef struct packed {
    logic   en;
    idx_t   addr;
    entry_t data;
  } pal_wr_t;

endpackage

// ===== design/cgl_addr.sv =====
module cgl_addr (
  input  logic [cgl_pkg::CNT_W-1:0] color_count,
  input  logic [cgl_pkg::POS_W-1:0] position,
  output cgl_pkg::lookup_t          lookup
);

  logic [31:0]                 count_ext;
  cgl_pkg::idx_t               nm1;
  logic                        pos_neg;
  logic                        pos_zero;
  logic                        pos_ge_one;
  logic [cgl_pkg::SCALED_W-1:0] scaled;
  cgl_pkg::idx_t               idx;

  assign count_ext  = {{(32-cgl_pkg::CNT_W){1'b0}}, color_count};
  assign pos_neg    = position[cgl_pkg::POS_W-1];
  assign pos_zero   = (position == '0);
  assign pos_ge_one = !pos_neg && position[cgl_pkg::FRAC_BITS];

  // entries in use minus one, count saturated to 1..depth
  always_comb begin
    if (color_count == '0) begin
      nm1 = '0;
    end else if (count_ext > 32'(cgl_pkg::PALETTE_DEPTH)) begin
      nm1 = cgl_pkg::IDX_W'(cgl_pkg::PALETTE_DEPTH - 1);
    end else begin
      nm1 = cgl_pkg::IDX_W'(color_count - cgl_pkg::CNT_W'(1));
    end
  end

  assign scaled = cgl_pkg::SCALED_W'(position[cgl_pkg::FRAC_BITS-1:0])
                * cgl_pkg::SCALED_W'(nm1);

  always_comb begin
    idx = scaled[cgl_pkg::SCALED_W-1 -: cgl_pkg::IDX_W];
    if (idx >= nm1) begin
      idx = nm1 - cgl_pkg::IDX_W'(1);
    end
  end

  always_comb begin
    if (pos_ge_one) begin
      lookup.addr0 = nm1;
      lookup.addr1 = nm1;
      lookup.frac  = '0;
    end else if (pos_neg || pos_zero || nm1 == '0) begin
      lookup.addr0 = '0;
      lookup.addr1 = '0;
      lookup.frac  = '0;
    end else begin
      lookup.addr0 = idx;
      lookup.addr1 = idx + cgl_pkg::IDX_W'(1);
      lookup.frac  = scaled[cgl_pkg::FRAC_BITS-1:0];
    end
  end

endmodule

// ===== design/cgl_palette.sv =====
module cgl_palette (
  input  logic             clk,
  input  cgl_pkg::pal_wr_t wr,
  input  logic             rd_en,
  input  cgl_pkg::idx_t    rd_addr0,
  input  cgl_pkg::idx_t    rd_addr1,
  output cgl_pkg::entry_t  rd_data0,
  output cgl_pkg::entry_t  rd_data1
);

  cgl_pkg::entry_t mem [cgl_pkg::PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule

// ===== design/cgl_lane.sv =====
module cgl_lane (
  input  cgl_pkg::chan_t p0,
  input  cgl_pkg::chan_t p1,
  input  cgl_pkg::frac_t frac,
  output cgl_pkg::chan_t blend
);

  localparam int PROD_W = cgl_pkg::CHAN_W + cgl_pkg::FRAC_BITS + 3;

  logic signed [PROD_W-1:0] diff;
  logic signed [PROD_W-1:0] weight;
  logic signed [PROD_W-1:0] base;
  logic signed [PROD_W-1:0] sum;
  logic signed [PROD_W-1:0] quot;

  assign diff   = $signed(PROD_W'(p1)) - $signed(PROD_W'(p0));
  assign weight = $signed(PROD_W'(frac));
  assign base   = $signed(PROD_W'(p0) << cgl_pkg::FRAC_BITS);
  assign sum    = base + diff * weight;
  assign quot   = sum >>> cgl_pkg::FRAC_BITS;

  // floor, then clamp into channel range
  always_comb begin
    if (sum < 0) begin
      blend = '0;
    end else if (quot > $signed(PROD_W'({cgl_pkg::CHAN_W{1'b1}}))) begin
      blend = '1;
    end else begin
      blend = quot[cgl_pkg::CHAN_W-1:0];
    end
  end

endmodule

// ===== design/color_gradient_lookup_core.sv =====
// a lookup word passes the stage 1, stage 2 and output registers before it shows on out_valid
// throughput: one word per cycle while out_stall is low, address calc -> palette read -> lane blend
// a palette write word retires in stage 1 and gives no result
// reset clears the pipeline valids and sets the color count to 1
// the palette itself is not cleared; an entry reads as garbage until written
module color_gradient_lookup_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [cgl_pkg::CNT_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic [cgl_pkg::IDX_W-1:0]   in_entry_index,
  input  logic [cgl_pkg::CHAN_W-1:0]  in_red,
  input  logic [cgl_pkg::CHAN_W-1:0]  in_green,
  input  logic [cgl_pkg::CHAN_W-1:0]  in_blue,
  input  logic [cgl_pkg::CHAN_W-1:0]  in_alpha,
  input  logic signed [cgl_pkg::POS_W-1:0] in_position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cgl_pkg::CHAN_W-1:0]  out_red,
  output logic [cgl_pkg::CHAN_W-1:0]  out_green,
  output logic [cgl_pkg::CHAN_W-1:0]  out_blue,
  output logic [cgl_pkg::CHAN_W-1:0]  out_alpha
);

  // color count register
  logic [cgl_pkg::CNT_W-1:0] color_count_r;

  // stage 1: decoded word, either a palette write or a lookup
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_wr_r;
  cgl_pkg::idx_t     s1_waddr_r;
  cgl_pkg::entry_t   s1_wdata_r;
  cgl_pkg::lookup_t  s1_lookup_r;
  cgl_pkg::lookup_t  lookup;

  // stage 2: palette data registered in the memory
  logic              s2_valid_r, s2_valid_nxt;
  cgl_pkg::frac_t    s2_frac_r;
  cgl_pkg::entry_t   rd_data0;
  cgl_pkg::entry_t   rd_data1;

  // stage 3: merged output register
  logic              out_valid_r, out_valid_nxt;
  cgl_pkg::chan_t    blend [cgl_pkg::NUM_CHAN];
  cgl_pkg::chan_t    out_chan_r [cgl_pkg::NUM_CHAN];

  logic              rdy3, rdy2, rdy1;
  logic              accept;
  logic              s1_leave;
  logic              s1_to_s2;
  logic              s2_to_s3;
  cgl_pkg::pal_wr_t  pal_wr;

  // per-stage ready chain, so an empty stage can fill while the output waits
  assign rdy3     = !out_valid_r || !out_stall;
  assign rdy2     = !s2_valid_r || rdy3;
  assign s1_leave = s1_valid_r && (s1_wr_r || rdy2);
  assign rdy1     = !s1_valid_r || s1_leave;
  assign in_stall = !rdy1;
  assign accept   = in_valid && rdy1;

  // writes retire in stage 1, in order with the reads of later lookups
  assign s1_to_s2 = s1_valid_r && !s1_wr_r && rdy2;
  assign s2_to_s3 = s2_valid_r && rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_count_r <= cgl_pkg::CNT_W'(1);
    end else if (cfg_wr_en) begin
      color_count_r <= cfg_wr_data;
    end
  end

  cgl_addr u_addr (
    .color_count (color_count_r),
    .position    (in_position),
    .lookup      (lookup)
  );

  assign s1_valid_nxt = accept || (s1_valid_r && !s1_leave);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_wr_r     <= (in_mode == cgl_pkg::MODE_WRITE);
      s1_waddr_r  <= in_entry_index;
      s1_wdata_r  <= {in_red, in_green, in_blue, in_alpha};
      s1_lookup_r <= lookup;
    end
  end

  assign pal_wr.en   = s1_valid_r && s1_wr_r;
  assign pal_wr.addr = s1_waddr_r;
  assign pal_wr.data = s1_wdata_r;

  cgl_palette u_palette (
    .clk      (clk),
    .wr       (pal_wr),
    .rd_en    (s1_to_s2),
    .rd_addr0 (s1_lookup_r.addr0),
    .rd_addr1 (s1_lookup_r.addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  assign s2_valid_nxt = s1_to_s2 || (s2_valid_r && !rdy3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_to_s2) begin
      s2_frac_r <= s1_lookup_r.frac;
    end
  end

  // one blend lane per channel, red in the top byte
  for (genvar k = 0; k < cgl_pkg::NUM_CHAN; k++) begin : g_lane
    cgl_lane u_lane (
      .p0    (rd_data0[cgl_pkg::ENTRY_W-1-cgl_pkg::CHAN_W*k -: cgl_pkg::CHAN_W]),
      .p1    (rd_data1[cgl_pkg::ENTRY_W-1-cgl_pkg::CHAN_W*k -: cgl_pkg::CHAN_W]),
      .frac  (s2_frac_r),
      .blend (blend[k])
    );
  end

  assign out_valid_nxt = s2_to_s3 || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // merge the lane results into one output word
  always_ff @(posedge clk) begin
    if (s2_to_s3) begin
      for (int k = 0; k < cgl_pkg::NUM_CHAN; k++) begin
        out_chan_r[k] <= blend[k];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_chan_r[0];
  assign out_green = out_chan_r[1];
  assign out_blue  = out_chan_r[2];
  assign out_alpha = out_chan_r[3];

  // an empty decode stage never pushes back on the input
  a_empty_s1_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty decode stage");

  // a blocked palette stage keeps its word
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !rdy3) |=> s2_valid_r)
    else $error("palette stage word lost under stall");

  // a blocked lookup keeps its addresses until the read happens
  a_s1_lookup_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_wr_r && !rdy2) |=>
      (s1_valid_r && !s1_wr_r && $stable(s1_lookup_r)))
    else $error("stalled lookup changed before palette read");

  // a write word never produces a result
  a_write_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_wr_r) |=> !(s2_valid_r && !$past(s2_valid_r) && !$past(s1_to_s2)))
    else $error("palette write reached the read stage");

endmodule
